// ===== hdl/bencode_contact_dict_parser_unit_defines.svh =====
// assertion macros for the contact dictionary parser
`ifndef BENCODE_CONTACT_DICT_PARSER_UNIT_DEFINES_SVH
`define BENCODE_CONTACT_DICT_PARSER_UNIT_DEFINES_SVH

// implication checked on every edge outside reset
`define BCD_ASSERT_IMP(label, clk_s, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// non-overlapping implication: the consequent is checked on the next edge
`define BCD_ASSERT_NEXT(label, clk_s, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/bcdp_pkg.sv =====
package bcdp_pkg;
	localparam int HOST_LIMIT = 46;
	localparam int ID_BYTES = 20;

	localparam logic [1:0] KIND_ID = 2'd0;
	localparam logic [1:0] KIND_HOST = 2'd1;
	localparam logic [1:0] KIND_DONE = 2'd2;
	localparam logic [1:0] KIND_ERR = 2'd3;

	localparam logic [7:0] CH_D = 8'h64;
	localparam logic [7:0] CH_E = 8'h65;
	localparam logic [7:0] CH_I = 8'h69;
	localparam logic [7:0] CH_COLON = 8'h3a;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_ZERO = 8'h30;

	// byte class from the front end
	typedef struct packed {
		logic [7:0] data;
		logic last;
		logic is_dig;
		logic [3:0] dig;
	} bcdp_item_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [15:0] value;
		logic [5:0] position;
		logic [15:0] consumed_count;
	} bcdp_res_t;

	function automatic logic [7:0] key_char(input logic host, input logic [1:0] i);
		logic [7:0] c;
		c = 8'h00;
		unique case (i)
			2'd0: c = host ? 8'h68 : 8'h70;
			2'd1: c = 8'h6f;
			2'd2: c = host ? 8'h73 : 8'h72;
			2'd3: c = 8'h74;
			default: c = 8'h00;
		endcase
		return c;
	endfunction
endpackage

// ===== hdl/bcdp_front.sv =====
module bcdp_front (
	input logic clk,
	input logic arst_n,
	input logic [7:0] data_byte,
	input logic last_byte,
	input logic in_valid,
	output logic in_ready,
	output bcdp_pkg::bcdp_item_t item,
	output logic item_valid,
	input logic item_ready
);
	import bcdp_pkg::*;

	// two-entry queue
	bcdp_item_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	bcdp_item_t cls;
	logic push, pop;

	always_comb begin
		cls.data = data_byte;
		cls.last = last_byte;
		cls.is_dig = (data_byte >= 8'h30) && (data_byte <= 8'h39);
		cls.dig = 4'(data_byte - CH_ZERO);
	end

	assign in_ready = (cnt_q != 2'd2);
	assign push = in_valid && in_ready;
	assign item_valid = (cnt_q != 2'd0);
	assign pop = item_valid && item_ready;
	assign item = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= cls;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule

// ===== hdl/bcdp_back.sv =====
module bcdp_back (
	input logic clk,
	input logic arst_n,
	input bcdp_pkg::bcdp_item_t item,
	input logic item_valid,
	output logic item_ready,
	output bcdp_pkg::bcdp_res_t res,
	output logic res_valid,
	input logic res_ready
);
	import bcdp_pkg::*;

	localparam logic [3:0] PH_START = 4'd0;
	localparam logic [3:0] PH_KEY_START = 4'd1;
	localparam logic [3:0] PH_KEY_LEN = 4'd2;
	localparam logic [3:0] PH_KEY_BYTES = 4'd3;
	localparam logic [3:0] PH_VAL_FIRST = 4'd4;
	localparam logic [3:0] PH_VAL_LEN = 4'd5;
	localparam logic [3:0] PH_VAL_BYTES = 4'd6;
	localparam logic [3:0] PH_INT_I = 4'd7;
	localparam logic [3:0] PH_INT_BODY = 4'd8;
	localparam logic [3:0] PH_IDLE = 4'd9;

	logic [3:0] ph_q, ph_d;
	logic [7:0] len_q, len_d;
	logic [5:0] idx_q, idx_d;
	logic [2:0] km_q, km_d;
	logic [15:0] iacc_q, iacc_d;
	logic [2:0] if_q, if_d;
	logic [2:0] found_q, found_d;
	logic [15:0] port_q, port_d;
	logic [5:0] hlen_q, hlen_d;
	logic [15:0] bcnt_q, bcnt_d;

	bcdp_res_t out_d;
	logic emit;
	logic fire;
	logic [1:0] r;
	logic [11:0] len_mul;
	logic [7:0] len_next;
	logic [6:0] idx_inc;
	logic [1:0] ki;
	logic [7:0] b;

	// output register is free or being drained
	assign item_ready = !res_valid || res_ready;
	assign fire = item_valid && item_ready;
	assign b = item.data;

	always_comb begin
		len_mul = 12'(len_q) * 12'd10 + 12'(item.dig);
		len_next = (len_mul > 12'd255) ? 8'd255 : len_mul[7:0];
	end

	always_comb begin
		ph_d = ph_q; len_d = len_q; idx_d = idx_q; km_d = km_q;
		iacc_d = iacc_q; if_d = if_q; found_d = found_q; port_d = port_q;
		hlen_d = hlen_q; bcnt_d = bcnt_q;
		r = 2'd0;
		emit = 1'b0;
		out_d = '0;
		idx_inc = 7'(idx_q) + 7'd1;
		ki = idx_q[1:0];
		if (ph_q != PH_IDLE) begin
			if (bcnt_q != 16'hffff) bcnt_d = bcnt_q + 16'd1;
			unique case (ph_q)
				PH_START: begin
					if (b != CH_D) r = 2'd3;
					else ph_d = PH_KEY_START;
				end
				PH_KEY_START: begin
					if (b == CH_E) r = (found_q == 3'b111) ? 2'd2 : 2'd3;
					else if (!item.is_dig) r = 2'd3;
					else begin
						len_d = {4'd0, item.dig};
						ph_d = PH_KEY_LEN;
					end
				end
				PH_KEY_LEN, PH_VAL_LEN: begin
					if (item.is_dig) len_d = len_next;
					else if (b != CH_COLON) r = 2'd3;
					else if (ph_q == PH_KEY_LEN) begin
						if (len_q == 8'd2) km_d = 3'b001;
						else if (len_q == 8'd4) km_d = 3'b110;
						else r = 2'd3;
						idx_d = '0;
						ph_d = PH_KEY_BYTES;
					end else begin
						if (km_q == 3'b001) begin
							if (len_q != 8'(ID_BYTES)) r = 2'd3;
						end else if (len_q >= 8'(HOST_LIMIT)) r = 2'd3;
						idx_d = '0;
						if (len_q == 8'd0) begin
							if (km_q == 3'b001) found_d[0] = 1'b1;
							else begin
								found_d[1] = 1'b1;
								hlen_d = '0;
							end
							ph_d = PH_KEY_START;
						end else ph_d = PH_VAL_BYTES;
					end
				end
				PH_KEY_BYTES: begin
					if (km_q[0] && (ki > 2'd1 || b != (ki[0] ? 8'h64 : 8'h69))) km_d[0] = 1'b0;
					if (km_q[1] && key_char(1'b1, ki) != b) km_d[1] = 1'b0;
					if (km_q[2] && key_char(1'b0, ki) != b) km_d[2] = 1'b0;
					if (km_d == 3'b000) r = 2'd3;
					else if (8'(idx_inc) >= len_q) begin
						idx_d = '0;
						ph_d = (km_d == 3'b100) ? PH_INT_I : PH_VAL_FIRST;
					end else idx_d = idx_inc[5:0];
				end
				PH_VAL_FIRST: begin
					if (!item.is_dig) r = 2'd3;
					else begin
						len_d = {4'd0, item.dig};
						ph_d = PH_VAL_LEN;
					end
				end
				PH_VAL_BYTES: begin
					r = 2'd1;
					out_d.kind = (km_q == 3'b001) ? KIND_ID : KIND_HOST;
					out_d.value = {8'd0, b};
					out_d.position = idx_q;
					idx_d = idx_inc[5:0];
					if (8'(idx_inc) >= len_q) begin
						if (km_q == 3'b001) found_d[0] = 1'b1;
						else begin
							found_d[1] = 1'b1;
							hlen_d = len_q[5:0];
						end
						ph_d = PH_KEY_START;
					end
				end
				PH_INT_I: begin
					if (b != CH_I) r = 2'd3;
					else begin
						iacc_d = '0;
						if_d = '0;
						ph_d = PH_INT_BODY;
					end
				end
				PH_INT_BODY: begin
					if (b == CH_E) begin
						if (!if_q[1]) r = 2'd3;
						else begin
							port_d = if_q[0] ? 16'(16'd0 - iacc_q) : iacc_q;
							found_d[2] = 1'b1;
							ph_d = PH_KEY_START;
						end
					end else if (b == CH_MINUS && if_q == 3'd0) if_d = 3'b001;
					else if (!item.is_dig || if_q[2]) r = 2'd3;
					else begin
						if (!if_q[1] && item.dig == 4'd0) if_d[2] = 1'b1;
						if_d[1] = 1'b1;
						iacc_d = 16'(iacc_q * 16'd10) + 16'(item.dig);
					end
				end
				default: r = 2'd3;
			endcase
			if (r == 2'd1) emit = 1'b1;
			else if (r == 2'd2) begin
				emit = 1'b1;
				out_d.kind = KIND_DONE;
				out_d.value = port_q;
				out_d.position = hlen_q;
				out_d.consumed_count = bcnt_d;
				ph_d = PH_IDLE;
			end else if (r == 2'd3) begin
				emit = 1'b1;
				out_d.kind = KIND_ERR;
				ph_d = PH_IDLE;
			end
			if (item.last && ph_d != PH_IDLE) begin
				emit = 1'b1;
				out_d = '0;
				out_d.kind = KIND_ERR;
			end
		end
		if (item.last) begin
			ph_d = PH_START; len_d = '0; idx_d = '0; km_d = 3'b111;
			iacc_d = '0; if_d = '0; found_d = '0; port_d = '0;
			hlen_d = '0; bcnt_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= PH_START; len_q <= '0; idx_q <= '0; km_q <= 3'b111;
			iacc_q <= '0; if_q <= '0; found_q <= '0; port_q <= '0;
			hlen_q <= '0; bcnt_q <= '0;
			res_valid <= 1'b0;
		end else begin
			if (fire) begin
				ph_q <= ph_d; len_q <= len_d; idx_q <= idx_d; km_q <= km_d;
				iacc_q <= iacc_d; if_q <= if_d; found_q <= found_d; port_q <= port_d;
				hlen_q <= hlen_d; bcnt_q <= bcnt_d;
			end
			if (item_ready) res_valid <= fire && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && emit) res <= out_d;
	end
endmodule

// ===== hdl/bencode_contact_dict_parser_unit.sv =====
// bencoded contact dictionary parser: one buffer byte per transaction on
// s_axis (tlast marks the buffer end); id bytes, host characters, a done
// record and errors leave on m_axis. The front end classifies each byte
// into a two-entry queue, the parser state advances once per byte and
// registers at most one result, so bytes stream at one per cycle while
// m_axis is not stalled.
`include "bencode_contact_dict_parser_unit_defines.svh"
module bencode_contact_dict_parser_unit (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	input logic [7:0] s_axis_tdata, // data_byte
	input logic s_axis_tlast, // last_byte
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	output logic [39:0] m_axis_tdata, // value, position, consumed_count (2 pad)
	output logic [1:0] m_axis_tuser // kind
);
	import bcdp_pkg::*;

	bcdp_item_t item;
	logic item_valid, item_ready;
	bcdp_res_t res;

	bcdp_front u_front (
		.clk(clk), .arst_n(arst_n),
		.data_byte(s_axis_tdata), .last_byte(s_axis_tlast),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.item(item), .item_valid(item_valid), .item_ready(item_ready)
	);

	bcdp_back u_back (
		.clk(clk), .arst_n(arst_n),
		.item(item), .item_valid(item_valid), .item_ready(item_ready),
		.res(res), .res_valid(m_axis_tvalid), .res_ready(m_axis_tready)
	);

	assign m_axis_tdata = {2'b00, res.consumed_count, res.position, res.value};
	assign m_axis_tuser = res.kind;

	`BCD_ASSERT_NEXT(a_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result dropped while stalled")
	`BCD_ASSERT_IMP(a_err_zero, clk, arst_n, m_axis_tvalid && m_axis_tuser == KIND_ERR, m_axis_tdata == 40'd0, "error result carries data")
	`BCD_ASSERT_IMP(a_pos, clk, arst_n, m_axis_tvalid && (m_axis_tuser == KIND_ID || m_axis_tuser == KIND_HOST), m_axis_tdata[21:16] < 6'(HOST_LIMIT) && m_axis_tdata[39:22] == 18'd0, "string position out of range")
endmodule

// ===== verif/bencode_contact_dict_parser_unit_tb.sv =====
`timescale 1ns / 100ps
`default_nettype none

module bencode_contact_dict_parser_unit_tb;
	import bcdp_pkg::*;

	localparam int CYCLE_LIMIT = 2000000;
	localparam int DRAIN_CYCLES = 20;

	typedef enum logic [3:0] {
		P_START, P_KEY_START, P_KEY_LEN, P_KEY_BYTES, P_VAL_FIRST, P_VAL_LEN,
		P_VAL_BYTES, P_INT_I, P_INT_BODY, P_IDLE
	} phase_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [15:0] value;
		logic [5:0] position;
		logic [15:0] consumed_count;
	} contact_res_t;

	// directed rows: byte, last, and a typed-in expectation when chk is set
	typedef struct {
		logic [7:0] b;
		logic last;
		logic chk;
		logic [1:0] kind;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [7:0] s_axis_tdata = '0;
	logic s_axis_tlast = 1'b0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;
	logic [1:0] m_axis_tuser;

	bencode_contact_dict_parser_unit i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
	);

	always #5 clk = ~clk;

	// predictor state
	phase_t ph;
	logic [7:0] len_acc;
	logic [7:0] str_idx;
	logic [2:0] key_cand;
	logic [15:0] int_acc;
	logic [2:0] int_fl;
	logic [2:0] found;
	logic [15:0] port_q;
	logic [5:0] host_len_q;
	logic [15:0] byte_cnt;

	contact_res_t expected_results[$];
	int errors = 0;
	int n_results = 0;
	int n_done = 0;
	int n_err = 0;
	int sent = 0;
	longint cycles = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_off = 0;
	byte stream_q[$];
	// prediction for the most recently sent byte
	bit step_have = 0;
	contact_res_t step_res;

	function automatic bit is_digit(logic [7:0] b);
		return b >= "0" && b <= "9";
	endfunction

	function automatic logic [7:0] sat_len(logic [7:0] acc, logic [7:0] b);
		int v;
		v = acc * 10 + (b - "0");
		return v > 255 ? 8'd255 : v[7:0];
	endfunction

	function automatic void contact_clear();
		ph = P_START;
		len_acc = 0;
		str_idx = 0;
		key_cand = 3'b111;
		int_acc = 0;
		int_fl = 0;
		found = 0;
		port_q = 0;
		host_len_q = 0;
		byte_cnt = 0;
	endfunction

	function automatic void close_string();
		if (key_cand == 3'b001) begin
			found[0] = 1'b1;
		end else begin
			found[1] = 1'b1;
			host_len_q = len_acc[5:0];
		end
		ph = P_KEY_START;
	endfunction

	// 0 none, 1 data, 2 done, 3 error
	function automatic int contact_advance(logic [7:0] b);
		logic [1:0] i;
		logic [7:0] id_txt[2];
		logic [7:0] host_txt[4];
		logic [7:0] port_txt[4];
		id_txt = '{"i", "d"};
		host_txt = '{"h", "o", "s", "t"};
		port_txt = '{"p", "o", "r", "t"};
		case (ph)
			P_START: begin
				if (b != CH_D) return 3;
				ph = P_KEY_START;
				return 0;
			end
			P_KEY_START: begin
				if (b == CH_E) return (found == 3'b111) ? 2 : 3;
				if (!is_digit(b)) return 3;
				len_acc = sat_len(0, b);
				ph = P_KEY_LEN;
				return 0;
			end
			P_KEY_LEN: begin
				if (is_digit(b)) begin
					len_acc = sat_len(len_acc, b);
					return 0;
				end
				if (b != CH_COLON) return 3;
				if (len_acc == 2) key_cand = 3'b001;
				else if (len_acc == 4) key_cand = 3'b110;
				else return 3;
				str_idx = 0;
				ph = P_KEY_BYTES;
				return 0;
			end
			P_KEY_BYTES: begin
				i = str_idx[1:0];
				if (key_cand[0] && (i > 1 || id_txt[i[0]] != b)) key_cand[0] = 1'b0;
				if (key_cand[1] && host_txt[i] != b) key_cand[1] = 1'b0;
				if (key_cand[2] && port_txt[i] != b) key_cand[2] = 1'b0;
				if (key_cand == 0) return 3;
				str_idx = str_idx + 1;
				if (str_idx >= len_acc) begin
					str_idx = 0;
					ph = (key_cand == 3'b100) ? P_INT_I : P_VAL_FIRST;
				end
				return 0;
			end
			P_VAL_FIRST: begin
				if (!is_digit(b)) return 3;
				len_acc = sat_len(0, b);
				ph = P_VAL_LEN;
				return 0;
			end
			P_VAL_LEN: begin
				if (is_digit(b)) begin
					len_acc = sat_len(len_acc, b);
					return 0;
				end
				if (b != CH_COLON) return 3;
				if (key_cand == 3'b001) begin
					if (len_acc != ID_BYTES) return 3;
				end else if (len_acc >= HOST_LIMIT) begin
					return 3;
				end
				str_idx = 0;
				if (len_acc == 0) close_string();
				else ph = P_VAL_BYTES;
				return 0;
			end
			P_VAL_BYTES: return 1;
			P_INT_I: begin
				if (b != CH_I) return 3;
				int_acc = 0;
				int_fl = 0;
				ph = P_INT_BODY;
				return 0;
			end
			P_INT_BODY: begin
				if (b == CH_E) begin
					if (!int_fl[1]) return 3;
					port_q = int_fl[0] ? 16'(-int_acc) : int_acc;
					found[2] = 1'b1;
					ph = P_KEY_START;
					return 0;
				end
				if (b == CH_MINUS && int_fl == 0) begin
					int_fl = 3'b001;
					return 0;
				end
				if (!is_digit(b)) return 3;
				if (int_fl[2]) return 3;
				if (!int_fl[1] && b == CH_ZERO) int_fl[2] = 1'b1;
				int_fl[1] = 1'b1;
				int_acc = 16'(int_acc * 10 + (b - "0"));
				return 0;
			end
			default: return 3;
		endcase
	endfunction

	// returns 1 and fills r when the byte produces a result
	function automatic bit contact_step(logic [7:0] b, logic last, output contact_res_t r);
		int code;
		bit have;
		r = '0;
		have = 0;
		if (ph == P_IDLE) begin
			if (last) contact_clear();
			return 0;
		end
		if (byte_cnt != 16'hffff) byte_cnt = byte_cnt + 1;
		code = contact_advance(b);
		if (code == 1) begin
			r.kind = (key_cand == 3'b001) ? KIND_ID : KIND_HOST;
			r.value = {8'h00, b};
			r.position = str_idx[5:0];
			have = 1;
			str_idx = str_idx + 1;
			if (str_idx >= len_acc) close_string();
		end else if (code == 2) begin
			r.kind = KIND_DONE;
			r.value = port_q;
			r.position = host_len_q;
			r.consumed_count = byte_cnt;
			have = 1;
			ph = P_IDLE;
		end else if (code == 3) begin
			r.kind = KIND_ERR;
			have = 1;
			ph = P_IDLE;
		end
		if (last) begin
			if (ph != P_IDLE) begin
				r = '0;
				r.kind = KIND_ERR;
				have = 1;
			end
			contact_clear();
		end
		return have;
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t timeout", $time);
			$display("bencode_contact_dict_parser_unit_tb: done, errors");
			$finish;
		end
	end

	// receiver: random stalls, plus a long hold-off window
	always @(posedge clk) begin
		if (arst_n) begin
			m_axis_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// result checker
	always @(posedge clk) begin
		contact_res_t got;
		contact_res_t exp_r;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.kind = m_axis_tuser;
			got.value = m_axis_tdata[15:0];
			got.position = m_axis_tdata[21:16];
			got.consumed_count = m_axis_tdata[37:22];
			n_results++;
			if (got.kind == KIND_DONE) n_done++;
			if (got.kind == KIND_ERR) n_err++;
			if (expected_results.size() == 0) begin
				$display("%0t unexpected result: actual %p", $time, got);
				errors++;
			end else begin
				exp_r = expected_results.pop_front();
				if (got !== exp_r) begin
					$display("%0t mismatch: expected %p, actual %p", $time, exp_r, got);
					errors++;
				end
			end
		end
	end

	task automatic send_byte(logic [7:0] b, logic last);
		contact_res_t r;
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tlast <= last;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		step_have = contact_step(b, last, r);
		step_res = r;
		if (step_have) expected_results.push_back(r);
		sent++;
	endtask

	task automatic idle_sender();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic push_str(string s);
		foreach (s[k]) stream_q.push_back(s[k]);
	endtask

	task automatic push_rand_bytes(int n, bit printable);
		repeat (n) stream_q.push_back(8'(printable ? $urandom_range(33, 126) : $urandom_range(255)));
	endtask

	task automatic push_int(int v);
		push_str($sformatf("i%0de", v));
	endtask

	// builds one buffer into the byte queue and sends it, mostly well formed
	task automatic build_buffer();
		int sel;
		int n;
		int host_n;
		stream_q.delete();
		sel = $urandom_range(99);
		if (sel < 8) begin
			push_rand_bytes($urandom_range(1, 12), 0);
		end else begin
			push_str("d");
			n = $urandom_range(3, 5);
			for (int k = 0; k < n; k++) begin
				case ((k < 3) ? k : $urandom_range(2))
					0: begin
						push_str("2:id20:");
						push_rand_bytes(ID_BYTES, $urandom_range(1));
					end
					1: begin
						host_n = ($urandom_range(9) == 0) ? HOST_LIMIT - 1 : $urandom_range(0, 12);
						push_str($sformatf("4:host%0d:", host_n));
						push_rand_bytes(host_n, 1);
					end
					default: begin
						push_str("4:port");
						case ($urandom_range(5))
							0: push_int(-$urandom_range(0, 99999));
							1: push_int($urandom_range(0, 999999));
							default: push_int($urandom_range(0, 65535));
						endcase
					end
				endcase
			end
			push_str("e");
			// corruption of a random byte now and then
			if (sel < 25) stream_q[$urandom_range(stream_q.size() - 1)] = $urandom_range(255);
			// truncation or trailing junk
			if (sel >= 25 && sel < 32) begin
				n = $urandom_range(1, stream_q.size());
				while (stream_q.size() > n) void'(stream_q.pop_back());
			end
			if (sel >= 32 && sel < 40) push_rand_bytes($urandom_range(1, 6), 0);
		end
		foreach (stream_q[k]) send_byte(stream_q[k], k == stream_q.size() - 1);
	endtask

	task automatic wait_drained();
		int guard;
		guard = 0;
		while (expected_results.size() != 0 && guard < 100000) begin
			@(posedge clk);
			guard++;
		end
	endtask

	dir_row_t dir_rows[$];

	task automatic add_rows(string s, bit chk_last, logic [1:0] k);
		foreach (s[i]) begin
			dir_rows.push_back('{b: s[i], last: (i == s.len() - 1),
				chk: chk_last && (i == s.len() - 1), kind: k});
		end
	endtask

	initial begin
		contact_clear();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: error codes at a glance, full dictionaries via predictor
		add_rows("x", 1, KIND_ERR);
		add_rows("de", 1, KIND_ERR);
		add_rows("d3:", 1, KIND_ERR);
		add_rows("d4:portie", 1, KIND_ERR);
		add_rows("d4:porti01", 1, KIND_ERR);
		add_rows("d2:id19:", 1, KIND_ERR);
		add_rows("d4:host46:", 1, KIND_ERR);
		add_rows("d4:host999:", 1, KIND_ERR);
		add_rows("d4:porti-0e", 1, KIND_ERR);
		add_rows("d4:port", 1, KIND_ERR);
		foreach (dir_rows[i]) begin
			send_byte(dir_rows[i].b, dir_rows[i].last);
			if (dir_rows[i].chk && (!step_have || step_res.kind !== dir_rows[i].kind)) begin
				$display("%0t directed row %0d: expected kind %0d, actual %0d", $time, i,
					dir_rows[i].kind, step_res.kind);
				errors++;
			end
		end
		stream_q.delete();
		push_str("d2:id20:");
		for (int k = 0; k < 20; k++) stream_q.push_back(k == 0 ? 8'h00 : 8'hff);
		push_str("4:host0:4:porti-65535e");
		push_str("4:host45:");
		push_rand_bytes(45, 1);
		push_str("4:porti99999999ee");
		foreach (stream_q[k]) send_byte(stream_q[k], k == stream_q.size() - 1);
		idle_sender();
		wait_drained();

		// random phases with different idling mixes
		for (int p = 0; p < 4; p++) begin
			send_idle_pct = (p == 1 || p == 3) ? 82 : 0;
			recv_stall_pct = (p == 2 || p == 3) ? 82 : 0;
			if (p == 3) send_idle_pct = 18;
			if (p == 3) recv_stall_pct = 18;
			if (p == 0) begin
				// long receiver hold-off while bytes keep coming
				fork
					begin
						hold_off = 1;
						repeat (300) @(posedge clk);
						hold_off = 0;
					end
					begin
						repeat (3) build_buffer();
						idle_sender();
					end
				join
			end
			while (sent < 460 * (p + 1)) build_buffer();
			idle_sender();
			wait_drained();
		end

		idle_sender();
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_results.size() != 0) begin
			$display("%0t %0d expected results never arrived", $time, expected_results.size());
			errors++;
		end
		$display("sent %0d bytes, checked %0d results (%0d done, %0d errors)",
			sent, n_results, n_done, n_err);
		if (errors == 0) begin
			$display("bencode_contact_dict_parser_unit_tb: done, clean");
		end else begin
			$display("bencode_contact_dict_parser_unit_tb: done, errors");
		end
		$finish;
	end
endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+hdl
hdl/bcdp_pkg.sv
hdl/bcdp_front.sv
hdl/bcdp_back.sv
hdl/bencode_contact_dict_parser_unit.sv
verif/bencode_contact_dict_parser_unit_tb.sv
